/* hw/rtl/tec_pkg.sv */
// Shared constants, types and rounding helpers for the easing curve pipeline.
`timescale 1ns / 1ps

package tec_pkg;

  localparam int FRAC_BITS = 15;
  // Unsigned width that holds 0..ONE inclusive
  localparam int UW = FRAC_BITS + 1;
  localparam int CW = 17;                    // control height width
  localparam int IW = 18;                    // progress / eased width
  localparam int AW = UW + 1 + CW - FRAC_BITS; // rounded signed Bezier term
  localparam int RW = AW + 3;                // sum of all curve terms
  localparam int ONE = 1 << FRAC_BITS;
  localparam int HALF = 1 << (FRAC_BITS - 1);
  localparam int OUT_MIN = -(1 << (IW - 1));
  localparam int OUT_MAX = (1 << (IW - 1)) - 1;

  typedef enum logic [2:0] {
    MODE_LINEAR = 3'd0,
    MODE_SMOOTH = 3'd1,
    MODE_IN     = 3'd2,
    MODE_OUT    = 3'd3,
    MODE_INOUT  = 3'd4,
    MODE_BEZIER = 3'd5
  } mode_t;

  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_C0   = 2'd1;
  localparam logic [1:0] CFG_C1   = 2'd2;

  typedef logic [UW-1:0] ufx_t;

  typedef struct packed {
    mode_t mode;
    ufx_t  t;
    ufx_t  u;
  } clamp_t;

  typedef struct packed {
    mode_t mode;
    ufx_t  t;
    ufx_t  cube_t;
    ufx_t  cube_u;
    ufx_t  uut;
    ufx_t  utt;
    ufx_t  smooth;
  } poly_t;

  // Round half up of an unsigned product of two unit values
  function automatic ufx_t rnd_u(input logic [2*UW-1:0] p);
    logic [2*UW-1:0] s;
    s = p + (2*UW)'(HALF);
    return s[FRAC_BITS +: UW];
  endfunction

  // Round half up (floor after bias) of a signed unit-by-height product
  function automatic logic signed [AW-1:0] rnd_s(input logic signed [UW+CW:0] p);
    logic signed [UW+CW:0] s;
    s = p + (UW+CW+1)'(HALF);
    s = s >>> FRAC_BITS;
    return s[AW-1:0];
  endfunction

endpackage

/* hw/rtl/tec_clamp.sv */
// Input stage: clamp progress to the unit interval and form its complement.
`timescale 1ns / 1ps

module tec_clamp (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [tec_pkg::IW-1:0] progress,
  input  tec_pkg::mode_t          mode,
  output logic                    out_valid,
  input  logic                    out_ready,
  output tec_pkg::clamp_t         out_data
);

  tec_pkg::ufx_t t_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    if (progress < 0) begin
      t_next = '0;
    end else if (progress > tec_pkg::ONE) begin
      t_next = tec_pkg::UW'(tec_pkg::ONE);
    end else begin
      t_next = progress[tec_pkg::UW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data.mode <= mode;
      out_data.t    <= t_next;
      out_data.u    <= tec_pkg::UW'(tec_pkg::ONE) - t_next;
    end
  end

endmodule

/* hw/rtl/tec_poly.sv */
// Two stages of unsigned polynomial products: squares, then cubes and mixed terms.
`timescale 1ns / 1ps

module tec_poly (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tec_pkg::clamp_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output tec_pkg::poly_t  out_data
);

  localparam int UW = tec_pkg::UW;

  logic           sq_valid;
  logic           sq_ready;
  tec_pkg::mode_t sq_mode;
  tec_pkg::ufx_t  sq_t;
  tec_pkg::ufx_t  sq_u;
  tec_pkg::ufx_t  sq_tt;
  tec_pkg::ufx_t  sq_uu;
  tec_pkg::ufx_t  sq_ut;
  logic [UW:0]    slope;
  logic [2*UW:0]  smooth_prod;
  logic [2*UW:0]  smooth_sum;

  assign sq_ready = !out_valid || out_ready;
  assign in_ready = !sq_valid || sq_ready;

  // First stage: t*t, u*u, u*t
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (in_ready) begin
      sq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sq_mode <= in_data.mode;
      sq_t    <= in_data.t;
      sq_u    <= in_data.u;
      sq_tt   <= tec_pkg::rnd_u((2*UW)'(in_data.t) * (2*UW)'(in_data.t));
      sq_uu   <= tec_pkg::rnd_u((2*UW)'(in_data.u) * (2*UW)'(in_data.u));
      sq_ut   <= tec_pkg::rnd_u((2*UW)'(in_data.u) * (2*UW)'(in_data.t));
    end
  end

  // Smoothstep factor 3 - 2t, at most three units
  assign slope       = (UW+1)'(3 * tec_pkg::ONE) - {sq_t, 1'b0};
  assign smooth_prod = (2*UW+1)'({1'b0, sq_tt}) * (2*UW+1)'(slope);
  assign smooth_sum  = smooth_prod + (2*UW+1)'(tec_pkg::HALF);

  // Second stage: cubes, mixed Bezier terms, smoothstep
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sq_ready) begin
      out_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_valid && sq_ready) begin
      out_data.mode   <= sq_mode;
      out_data.t      <= sq_t;
      out_data.cube_t <= tec_pkg::rnd_u((2*UW)'(sq_tt) * (2*UW)'(sq_t));
      out_data.cube_u <= tec_pkg::rnd_u((2*UW)'(sq_uu) * (2*UW)'(sq_u));
      out_data.uut    <= tec_pkg::rnd_u((2*UW)'(sq_uu) * (2*UW)'(sq_t));
      out_data.utt    <= tec_pkg::rnd_u((2*UW)'(sq_ut) * (2*UW)'(sq_t));
      out_data.smooth <= smooth_sum[tec_pkg::FRAC_BITS +: UW];
    end
  end

endmodule

/* hw/rtl/tec_mix.sv */
// Bezier weighting by control heights, curve selection and output saturation.
`timescale 1ns / 1ps

module tec_mix (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tec_pkg::poly_t                 in_data,
  input  logic signed [tec_pkg::CW-1:0]  ctrl_y_first,
  input  logic signed [tec_pkg::CW-1:0]  ctrl_y_second,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [tec_pkg::IW-1:0]  eased
);

  localparam int UW = tec_pkg::UW;
  localparam int AW = tec_pkg::AW;
  localparam int RW = tec_pkg::RW;
  localparam int PW = tec_pkg::UW + tec_pkg::CW + 1;

  logic                  wt_valid;
  logic                  wt_ready;
  tec_pkg::poly_t        wt;
  logic signed [AW-1:0]  wt_a;
  logic signed [AW-1:0]  wt_b;
  logic signed [RW-1:0]  r;
  logic signed [RW-1:0]  t_w;
  logic signed [RW-1:0]  ct_w;
  logic signed [RW-1:0]  cu_w;
  logic signed [RW-1:0]  one_w;

  assign wt_ready = !out_valid || out_ready;
  assign in_ready = !wt_valid || wt_ready;

  // Weighting stage: scale mixed terms by the control heights
  always_ff @(posedge clk) begin
    if (rst) begin
      wt_valid <= 1'b0;
    end else if (in_ready) begin
      wt_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      wt   <= in_data;
      wt_a <= tec_pkg::rnd_s(PW'($signed({1'b0, in_data.uut})) * PW'(ctrl_y_first));
      wt_b <= tec_pkg::rnd_s(PW'($signed({1'b0, in_data.utt})) * PW'(ctrl_y_second));
    end
  end

  assign t_w   = $signed({{(RW-UW){1'b0}}, wt.t});
  assign ct_w  = $signed({{(RW-UW){1'b0}}, wt.cube_t});
  assign cu_w  = $signed({{(RW-UW){1'b0}}, wt.cube_u});
  assign one_w = RW'(tec_pkg::ONE);

  always_comb begin
    case (wt.mode)
      tec_pkg::MODE_SMOOTH: r = $signed({{(RW-UW){1'b0}}, wt.smooth});
      tec_pkg::MODE_IN:     r = ct_w;
      tec_pkg::MODE_OUT:    r = one_w - cu_w;
      tec_pkg::MODE_INOUT: begin
        if (wt.t < UW'(tec_pkg::HALF)) begin
          r = ct_w <<< 2;
        end else begin
          r = one_w - (cu_w <<< 2);
        end
      end
      tec_pkg::MODE_BEZIER: begin
        r = RW'(wt_a) * RW'(3) + RW'(wt_b) * RW'(3) + ct_w;
      end
      default: r = t_w;
    endcase
  end

  // Output stage: saturate to the result range
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wt_ready) begin
      out_valid <= wt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wt_valid && wt_ready) begin
      if (r < RW'(tec_pkg::OUT_MIN)) begin
        eased <= tec_pkg::IW'(tec_pkg::OUT_MIN);
      end else if (r > RW'(tec_pkg::OUT_MAX)) begin
        eased <= tec_pkg::IW'(tec_pkg::OUT_MAX);
      end else begin
        eased <= r[tec_pkg::IW-1:0];
      end
    end
  end

endmodule

/* hw/rtl/transition_easing_curve.sv */
// Top level of the transition easing curve evaluator.
`timescale 1ns / 1ps
//
//  Channel   Direction  Beat contents
//  --------  ---------  ------------------------------------------------------
//  s_axis    in         tdata[17:0] progress, signed Q2.15 (bits 23:18 zero)
//  m_axis    out        tdata[17:0] eased, signed Q2.15 (bits 23:18 zero)
//  cfg       in         cfg_index selects easing_mode / ctrl_y_first /
//                       ctrl_y_second, cfg_data carries the value
//
//  One beat enters per clock while s_axis_tready is high; a result is offered
//  on m_axis once its input beat has passed the five register stages (clamp,
//  squares, cubes, height weighting, select and saturate), the first loaded at
//  the accepting edge, with at most one multiplier deep per stage.
//  rst is synchronous and clears every stage valid and the registers to
//  linear mode, c0 = 0, c1 = 1.0.
//  A stall on m_axis holds each stage only while the one after it is full;
//  bubbles close up, so s_axis keeps taking beats until the pipe is full.
//  cfg is always ready; writes take effect at once and are meant for idle.

module transition_easing_curve (
  input  logic        clk,
  input  logic        rst,
  // progress in [17:0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  // eased in [17:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  tec_pkg::mode_t                   easing_mode;
  logic signed [tec_pkg::CW-1:0]    ctrl_y_first;
  logic signed [tec_pkg::CW-1:0]    ctrl_y_second;

  logic                             cl_valid;
  logic                             cl_ready;
  tec_pkg::clamp_t                  cl_data;
  logic                             po_valid;
  logic                             po_ready;
  tec_pkg::poly_t                   po_data;
  logic signed [tec_pkg::IW-1:0]    eased;

  assign cfg_ready = 1'b1;

  // Configuration registers; index 3 is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      easing_mode   <= tec_pkg::MODE_LINEAR;
      ctrl_y_first  <= '0;
      ctrl_y_second <= tec_pkg::CW'(tec_pkg::ONE);
    end else if (cfg_valid) begin
      case (cfg_index)
        tec_pkg::CFG_MODE: easing_mode   <= tec_pkg::mode_t'(cfg_data[2:0]);
        tec_pkg::CFG_C0:   ctrl_y_first  <= $signed(cfg_data);
        tec_pkg::CFG_C1:   ctrl_y_second <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Stage 1: clamp progress, form u = 1 - t
  tec_clamp u_clamp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .progress  ($signed(s_axis_tdata[tec_pkg::IW-1:0])),
    .mode      (easing_mode),
    .out_valid (cl_valid),
    .out_ready (cl_ready),
    .out_data  (cl_data)
  );

  // Stages 2 and 3: squares, then cubes and mixed products
  tec_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cl_valid),
    .in_ready  (cl_ready),
    .in_data   (cl_data),
    .out_valid (po_valid),
    .out_ready (po_ready),
    .out_data  (po_data)
  );

  // Stages 4 and 5: weight by control heights, select curve, saturate
  tec_mix u_mix (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (po_valid),
    .in_ready      (po_ready),
    .in_data       (po_data),
    .ctrl_y_first  (ctrl_y_first),
    .ctrl_y_second (ctrl_y_second),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .eased         (eased)
  );

  assign m_axis_tdata = {{(24 - tec_pkg::IW){1'b0}}, eased};

endmodule
